// ===== hw/rtl/keyed_entry_table_with_access_counts_assert.svh =====
// Assertion macros for the keyed entry table.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef KEYED_ENTRY_TABLE_WITH_ACCESS_COUNTS_ASSERT_SVH
`define KEYED_ENTRY_TABLE_WITH_ACCESS_COUNTS_ASSERT_SVH

// expr holds at every clock edge out of reset
`define KET_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons holds in the same cycle as ante
`define KET_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons holds in the cycle after ante
`define KET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ket_pkg.sv =====
// Shared types and constants for the keyed entry table.
// No dependencies; used by the interfaces, the slot cell and the top level.
package ket_pkg;

  localparam int KEY_W    = 16;
  localparam int HANDLE_W = 32;
  localparam int HITS_W   = 32;
  localparam int TOTAL_W  = 7;

  typedef enum logic [1:0] {
    REQ_ADD        = 2'd0,
    REQ_REMOVE     = 2'd1,
    REQ_GET        = 2'd2,
    REQ_GET_ACCESS = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t             req_type;
    logic [KEY_W-1:0]      key;
    logic [HANDLE_W-1:0]   content_handle;
  } in_word_t;

  typedef struct packed {
    logic                  found;
    logic                  rejected_full;
    logic [HANDLE_W-1:0]   content_out;
    logic [HITS_W-1:0]     access_count;
    logic [TOTAL_W-1:0]    entry_total;
    logic [TOTAL_W-1:0]    peak_total;
  } out_word_t;

  // contents of one table slot
  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [HANDLE_W-1:0]   handle;
    logic [HITS_W-1:0]     hits;
  } slot_t;

  // request token walking down the cell chain
  typedef struct packed {
    logic                  vld;
    req_type_t             req;
    logic [KEY_W-1:0]      key;
    logic [HANDLE_W-1:0]   handle;
    logic                  found;   // a cell upstream matched the key
    logic                  placed;  // an add was stored upstream
    logic                  shift;   // remove in progress: cells pull from their neighbor
    logic [HITS_W-1:0]     data;    // handle or hit count picked up at the match
  } tok_t;

endpackage

// ===== hw/rtl/ket_ifs.sv =====
// Valid/ready channel interfaces for request and result words.
// Depends on ket_pkg.
interface ket_in_if import ket_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ket_out_if import ket_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ket_cell.sv =====
// One table slot: holds key, handle, hit counter and valid mark, and acts on
// the request token passing through it. Depends on ket_pkg.
module ket_cell import ket_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  tok_t  tok_i,
  input  slot_t nb_slot_i,
  input  logic  nb_vld_i,
  output tok_t  tok_o,
  output slot_t slot_o,
  output logic  vld_o
);

  slot_t slot_r, slot_nxt;
  logic  vld_r, vld_nxt;
  tok_t  tok_r, tok_nxt;

  always_comb begin
    slot_nxt = slot_r;
    vld_nxt  = vld_r;
    tok_nxt  = tok_i;
    if (tok_i.vld) begin
      if (tok_i.shift) begin
        // close up the gap left by a removal
        slot_nxt = nb_slot_i;
        vld_nxt  = nb_vld_i;
      end else if (!tok_i.found && !tok_i.placed) begin
        case (tok_i.req)
          REQ_ADD: begin
            if (!vld_r) begin
              slot_nxt.key    = tok_i.key;
              slot_nxt.handle = tok_i.handle;
              slot_nxt.hits   = '0;
              vld_nxt         = 1'b1;
              tok_nxt.placed  = 1'b1;
            end
          end
          default: begin
            if (vld_r && slot_r.key == tok_i.key) begin
              tok_nxt.found = 1'b1;
              case (tok_i.req)
                REQ_GET: begin
                  tok_nxt.data  = slot_r.handle;
                  slot_nxt.hits = slot_r.hits + 1'b1;
                end
                REQ_GET_ACCESS: begin
                  tok_nxt.data = slot_r.hits;
                end
                REQ_REMOVE: begin
                  slot_nxt      = nb_slot_i;
                  vld_nxt       = nb_vld_i;
                  tok_nxt.shift = 1'b1;
                end
                default: ;
              endcase
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      tok_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign tok_o  = tok_r;
  assign slot_o = slot_r;
  assign vld_o  = vld_r;

endmodule

// ===== hw/rtl/keyed_entry_table_with_access_counts.sv =====
// Keyed entry table with access counts.
// Channels: in_ch carries request words (req_type, key, content_handle);
// out_ch returns one result word per request. Both are valid/ready; a word
// moves on a clock edge where valid and ready are both high.
// Requests: add appends an entry, remove deletes the oldest entry with the
// key and closes up the order, get returns its handle and bumps its hit
// counter, get_access returns the hit counter.
// A request token walks down a chain of CAPACITY slot cells, one cell per
// cycle; its result goes via a pending register into the output register.
// One request is in the chain at a time: in_ch.ready rises again once the
// previous result has moved into the output register.
// A stalled receiver holds the result in the output register; one more
// result can finish and wait behind it before in_ch.ready stays low.
// Reset (rst_n low, synchronous) clears all valid marks, the entry and peak
// counts and both channels; the table is usable on the next cycle.
// Depends on ket_pkg, ket_ifs, ket_cell and the assertion macro header.
`include "keyed_entry_table_with_access_counts_assert.svh"

module keyed_entry_table_with_access_counts import ket_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  ket_in_if.sink    in_ch,
  ket_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  tok_t  tok_w  [CAPACITY+1];
  slot_t slot_w [CAPACITY+1];
  logic  vld_w  [CAPACITY+1];

  logic [CAPACITY-1:0] cell_vld;
  logic [CAPACITY-1:0] tok_vld;

  logic             in_fire;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic [CNT_W-1:0] peak_r, peak_nxt;
  out_word_t        pend_r, pend_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  out_word_t        out_data_r, out_data_nxt;
  logic             out_vld_r, out_vld_nxt;
  tok_t             last;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy_r;

  always_comb begin
    tok_w[0]        = '0;
    tok_w[0].vld    = in_fire;
    tok_w[0].req    = in_ch.data.req_type;
    tok_w[0].key    = in_ch.data.key;
    tok_w[0].handle = in_ch.data.content_handle;
  end

  // past the last cell: nothing valid to pull in on a removal
  assign slot_w[CAPACITY] = '0;
  assign vld_w[CAPACITY]  = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ket_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_i     (tok_w[i]),
      .nb_slot_i (slot_w[i+1]),
      .nb_vld_i  (vld_w[i+1]),
      .tok_o     (tok_w[i+1]),
      .slot_o    (slot_w[i]),
      .vld_o     (vld_w[i])
    );
    assign cell_vld[i] = vld_w[i];
    assign tok_vld[i]  = tok_w[i+1].vld;
  end

  assign last = tok_w[CAPACITY];

  always_comb begin
    busy_nxt     = busy_r;
    live_nxt     = live_r;
    peak_nxt     = peak_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    out_data_nxt = out_data_r;
    out_vld_nxt  = out_vld_r;

    if (last.vld) begin
      if (last.placed) begin
        live_nxt = live_r + 1'b1;
      end else if (last.found && last.req == REQ_REMOVE) begin
        live_nxt = live_r - 1'b1;
      end
      if (live_nxt > peak_r) begin
        peak_nxt = live_nxt;
      end
      pend_nxt.found         = last.found;
      pend_nxt.rejected_full = (last.req == REQ_ADD) && !last.placed;
      pend_nxt.content_out   = (last.req == REQ_GET && last.found) ? last.data : '0;
      pend_nxt.access_count  = (last.req == REQ_GET_ACCESS && last.found) ? last.data : '0;
      pend_nxt.entry_total   = TOTAL_W'(live_nxt);
      pend_nxt.peak_total    = TOTAL_W'(peak_nxt);
      pend_vld_nxt           = 1'b1;
    end

    if (pend_vld_r && (!out_vld_r || out_ch.ready)) begin
      out_data_nxt = pend_r;
      out_vld_nxt  = 1'b1;
      pend_vld_nxt = 1'b0;
      busy_nxt     = 1'b0;
    end else if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    if (in_fire) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      live_r     <= '0;
      peak_r     <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      live_r     <= live_nxt;
      peak_r     <= peak_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  `KET_ASSERT_ALWAYS(a_live_within_cap, live_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `KET_ASSERT_ALWAYS(a_peak_covers_live, peak_r >= live_r, "peak count below entry count")
  `KET_ASSERT_ALWAYS(a_single_token, $onehot0(tok_vld), "more than one request in the chain")
  `KET_ASSERT_IMPL(a_marks_match_count, !busy_r, $countones(cell_vld) == int'(live_r),
                   "valid marks disagree with entry count")
  `KET_ASSERT_NEXT(a_busy_after_accept, in_fire, busy_r && !pend_vld_r,
                   "request accepted but chain not marked busy")

endmodule

// ===== bench/keyed_entry_table_with_access_counts_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the keyed entry table: directed and random requests,
// shadow table predicts every result word. Needs ket_pkg, ket_ifs and the top level.
module keyed_entry_table_with_access_counts_tb import ket_pkg::*; ();

  localparam int CAPACITY   = 64;
  localparam int CYCLE_CAP  = 1000000;
  localparam int SETTLE     = CAPACITY + 16;
  localparam int PRINT_CAP  = 50;

  logic clk;
  logic rst_n;

  ket_in_if  in_ch();
  ket_out_if out_ch();

  keyed_entry_table_with_access_counts #(.CAPACITY(CAPACITY)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the table, updated at each accepted request word
  logic [KEY_W-1:0]    tbl_key    [CAPACITY];
  logic [HANDLE_W-1:0] tbl_handle [CAPACITY];
  logic [HITS_W-1:0]   tbl_hits   [CAPACITY];
  int                  tbl_count;
  int                  tbl_peak;

  in_word_t  req_backlog[$];
  out_word_t due_results[$];
  logic [KEY_W-1:0] live_keys[$];  // stimulus-side view of keys in the table

  int        send_idle_pct;
  int        stall_pct;
  int        errors;
  int        cycle_cnt;
  int        n_checked;
  int        n_hits;
  int        n_refused;
  int        n_requests;
  out_word_t due_w;

  always #6 clk = ~clk;

  function automatic out_word_t predict_table_response(in_word_t w);
    out_word_t r;
    int        slot;
    int        i;
    r    = '0;
    slot = -1;
    if (w.req_type == REQ_ADD) begin
      if (tbl_count >= CAPACITY) begin
        r.rejected_full = 1'b1;
        n_refused++;
      end else begin
        tbl_key[tbl_count]    = w.key;
        tbl_handle[tbl_count] = w.content_handle;
        tbl_hits[tbl_count]   = '0;
        tbl_count++;
        if (tbl_count > tbl_peak) tbl_peak = tbl_count;
      end
    end else begin
      // oldest entry wins
      for (i = 0; i < tbl_count; i++) begin
        if (slot < 0 && tbl_key[i] == w.key) slot = i;
      end
      if (slot >= 0) begin
        r.found = 1'b1;
        n_hits++;
        case (w.req_type)
          REQ_REMOVE: begin
            for (i = slot; i + 1 < tbl_count; i++) begin
              tbl_key[i]    = tbl_key[i+1];
              tbl_handle[i] = tbl_handle[i+1];
              tbl_hits[i]   = tbl_hits[i+1];
            end
            tbl_count--;
          end
          REQ_GET: begin
            r.content_out  = tbl_handle[slot];
            tbl_hits[slot] = tbl_hits[slot] + 1'b1;
          end
          default: r.access_count = tbl_hits[slot];
        endcase
      end
    end
    r.entry_total = TOTAL_W'(tbl_count);
    r.peak_total  = TOTAL_W'(tbl_peak);
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    if (errors < PRINT_CAP)
      $display("ERROR @%0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic queue_request(req_type_t op, logic [KEY_W-1:0] key,
                               logic [HANDLE_W-1:0] handle);
    in_word_t w;
    int       idx;
    int       i;
    w.req_type       = op;
    w.key            = key;
    w.content_handle = handle;
    req_backlog.push_back(w);
    n_requests++;
    if (op == REQ_ADD && live_keys.size() < CAPACITY) begin
      live_keys.push_back(key);
    end else if (op == REQ_REMOVE) begin
      idx = -1;
      for (i = 0; i < live_keys.size(); i++) begin
        if (idx < 0 && live_keys[i] == key) idx = i;
      end
      if (idx >= 0) live_keys.delete(idx);
    end
  endtask

  // hit_pct: chance of reusing a key that is currently in the table
  function automatic logic [KEY_W-1:0] pick_key(int hit_pct);
    if (live_keys.size() > 0 && $urandom_range(0, 99) < hit_pct)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    if ($urandom_range(0, 1)) return KEY_W'($urandom);
    return KEY_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_type_t pick_lookup();
    case ($urandom_range(0, 2))
      0:       return REQ_REMOVE;
      1:       return REQ_GET;
      default: return REQ_GET_ACCESS;
    endcase
  endfunction

  // sender holds off until the table has answered everything
  task automatic wait_drained();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_ch.valid || due_results.size() != 0);
  endtask

  task automatic run_phase(int send_pct, int recv_pct);
    req_type_t op;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    // fill to capacity, then push past it
    while (live_keys.size() < CAPACITY) begin
      if ($urandom_range(0, 99) < 85) queue_request(REQ_ADD, pick_key(40), pick_handle());
      else queue_request(pick_lookup(), pick_key(60), pick_handle());
    end
    repeat (8) begin
      op = $urandom_range(0, 1) ? REQ_ADD : REQ_GET_ACCESS;
      queue_request(op, pick_key(80), pick_handle());
    end
    repeat (40) queue_request(req_type_t'($urandom_range(0, 3)), pick_key(70), pick_handle());
    // drain back to empty
    while (live_keys.size() > 0) begin
      op = ($urandom_range(0, 99) < 65) ? REQ_REMOVE : pick_lookup();
      queue_request(op, pick_key(90), pick_handle());
    end
    wait_drained();
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        due_results.push_back(predict_table_response(in_ch.data));
      if (!in_ch.valid || in_ch.ready) begin
        if (req_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.data  <= req_backlog.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result sink with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        flag_mismatch("result word with nothing pending",
                      longint'(out_ch.data.entry_total), longint'(0));
      end else begin
        due_w = due_results.pop_front();
        n_checked++;
        if (out_ch.data.found != due_w.found)
          flag_mismatch("found", longint'(out_ch.data.found), longint'(due_w.found));
        if (out_ch.data.rejected_full != due_w.rejected_full)
          flag_mismatch("rejected_full", longint'(out_ch.data.rejected_full),
                        longint'(due_w.rejected_full));
        if (out_ch.data.content_out != due_w.content_out)
          flag_mismatch("content_out", longint'(out_ch.data.content_out),
                        longint'(due_w.content_out));
        if (out_ch.data.access_count != due_w.access_count)
          flag_mismatch("access_count", longint'(out_ch.data.access_count),
                        longint'(due_w.access_count));
        if (out_ch.data.entry_total != due_w.entry_total)
          flag_mismatch("entry_total", longint'(out_ch.data.entry_total),
                        longint'(due_w.entry_total));
        if (out_ch.data.peak_total != due_w.peak_total)
          flag_mismatch("peak_total", longint'(out_ch.data.peak_total),
                        longint'(due_w.peak_total));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               due_results.size());
      $display("** keyed_entry_table_with_access_counts: FAILED **");
      $finish;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    errors        = 0;
    cycle_cnt     = 0;
    n_checked     = 0;
    n_hits        = 0;
    n_refused     = 0;
    n_requests    = 0;
    tbl_count     = 0;
    tbl_peak      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, duplicates, misses, removal order, empty table
    queue_request(REQ_ADD,        16'h0000, 32'h0000_0000);
    queue_request(REQ_ADD,        16'hFFFF, 32'hFFFF_FFFF);
    queue_request(REQ_ADD,        16'h0000, 32'h0000_0005);
    queue_request(REQ_GET,        16'h0000, 32'hDEAD_BEEF);
    queue_request(REQ_GET_ACCESS, 16'h0000, 32'h0);
    queue_request(REQ_GET,        16'h0000, 32'h0);
    queue_request(REQ_GET_ACCESS, 16'h0000, 32'h0);
    queue_request(REQ_GET,        16'hFFFF, 32'h0);
    queue_request(REQ_GET,        16'h1234, 32'h0);
    queue_request(REQ_GET_ACCESS, 16'h1234, 32'h0);
    queue_request(REQ_REMOVE,     16'h1234, 32'h0);
    queue_request(REQ_REMOVE,     16'h0000, 32'h0);
    queue_request(REQ_GET,        16'h0000, 32'h0);
    queue_request(REQ_GET_ACCESS, 16'h0000, 32'h0);
    queue_request(REQ_REMOVE,     16'hFFFF, 32'hFFFF_FFFF);
    queue_request(REQ_REMOVE,     16'h0000, 32'h0);
    queue_request(REQ_REMOVE,     16'h0000, 32'h0);
    queue_request(REQ_GET,        16'hFFFF, 32'h0);
    queue_request(REQ_GET_ACCESS, 16'h8001, 32'h0);
    queue_request(REQ_ADD,        16'h5AA5, 32'hA5A5_5A5A);
    queue_request(REQ_REMOVE,     16'h5AA5, 32'h0);
    wait_drained();

    run_phase(0, 0);
    run_phase(45, 0);
    run_phase(0, 45);
    run_phase(28, 28);

    repeat (SETTLE) @(negedge clk);
    $display("%0d requests sent, %0d results checked: %0d lookups hit, %0d adds refused,",
             n_requests, n_checked, n_hits, n_refused);
    $display("table filled to %0d entries in each of four back-pressure phases.", tbl_peak);
    if (errors == 0) begin
      $display("** keyed_entry_table_with_access_counts: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** keyed_entry_table_with_access_counts: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ket_pkg.sv
hw/rtl/ket_ifs.sv
hw/rtl/ket_cell.sv
hw/rtl/keyed_entry_table_with_access_counts.sv
bench/keyed_entry_table_with_access_counts_tb.sv
